// File: hw/rtl/pwmkt_pkg.sv
package pwmkt_pkg;

	// Counter registers of the PWM timer
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] CMP_RESET = CNT_W'(499);
	localparam logic [CNT_W-1:0] PER_RESET = CNT_W'(999);

	// Percent scale and the doubling limit of the period
	localparam int PCT = 100;
	localparam int DUTY_W = 7;
	localparam logic [31:0] DOUBLE_LIMIT = 32'd32676;

	// Divider widths: dividend holds (compare+1)*100, divisor holds period+1
	localparam int DIV_A_W = CNT_W + 7;
	localparam int DIV_B_W = CNT_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_A_W + 1);

	// Reciprocal of 100, rounded up: the floor is exact for any dividend below 2^DIV_A_W
	localparam int RCP_SHIFT = DIV_A_W + 7;
	localparam int RCP_W = DIV_A_W + 1;
	localparam int PRD_W = DIV_A_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_100 =
		RCP_W'(((64'd1 << RCP_SHIFT) + 64'd99) / 64'd100);

	// Key codes
	localparam logic [7:0] KEY_M = 8'h6D;
	localparam logic [7:0] KEY_Q = 8'h71;
	localparam logic [7:0] KEY_W = 8'h77;
	localparam logic [7:0] KEY_E = 8'h65;
	localparam logic [7:0] KEY_R = 8'h72;
	localparam logic [7:0] KEY_D = 8'h64;
	localparam logic [7:0] KEY_F = 8'h66;
	localparam logic [7:0] KEY_H = 8'h68;
	localparam logic [7:0] KEY_QM = 8'h3F;
	localparam logic [7:0] KEY_CR = 8'h0D;
	localparam logic [7:0] KEY_LF = 8'h0A;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_MODE,
		CMD_INC,
		CMD_DEC,
		CMD_HALF,
		CMD_DOUBLE,
		CMD_PDEC,
		CMD_PINC,
		CMD_HELP,
		CMD_NL
	} cmd_t;

	typedef enum logic [2:0] {
		RESP_NONE    = 3'd0,
		RESP_GENERAL = 3'd1,
		RESP_VOLT    = 3'd2,
		RESP_HELP    = 3'd3,
		RESP_NEWLINE = 3'd4
	} resp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_SCALE,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     prep;
		logic     div_start;
		logic     mul;
		logic     scale;
		logic     apply;
	} dp_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	function automatic cmd_t decode_key(input logic [7:0] key);
		cmd_t c;
		case (key) inside
			KEY_M:          c = CMD_MODE;
			KEY_Q:          c = CMD_INC;
			KEY_W:          c = CMD_DEC;
			KEY_E:          c = CMD_HALF;
			KEY_R:          c = CMD_DOUBLE;
			KEY_D:          c = CMD_PDEC;
			KEY_F:          c = CMD_PINC;
			KEY_H, KEY_QM:  c = CMD_HELP;
			KEY_CR, KEY_LF: c = CMD_NL;
			default:        c = CMD_NONE;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/pwmkt_key_if.sv
interface pwmkt_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

// File: hw/rtl/pwmkt_res_if.sv
interface pwmkt_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] compare_value;
	logic [15:0] period_value;
	logic        display_mode;
	logic [2:0]  response;

	modport source (output valid, output compare_value, output period_value,
		output display_mode, output response, input ready);
	modport sink (input valid, input compare_value, input period_value,
		input display_mode, input response, output ready);
endinterface

// File: hw/rtl/pwm_keystroke_tuner.sv
// Result: every key except e/r/d/f goes from the prep state straight to the apply state;
//   e/r/d/f first run a 23-step duty divide, multiply, reciprocal scale by 1/100.
// Keys: a new key is taken only once the last one is applied; the restoring divider makes
//   the period keys the longer ones. A pending result does not block the next key:
//   the output register parts the sides; a second pending result holds the input.
// Reset (arst_n low, asynchronous): compare 499, period 999, general mode, no result pending.
module pwm_keystroke_tuner (
	input  logic        clk,
	input  logic        arst_n,
	pwmkt_key_if.sink   key,
	pwmkt_res_if.source res
);
	import pwmkt_pkg::*;

	dp_ctrl_t ctl;
	dp_stat_t stat;

	// Sequencer: accept one key, run the divide/multiply/scale steps for period keys, write the result
	pwmkt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (key.valid),
		.in_ready (key.ready),
		.ctl      (ctl),
		.stat     (stat)
	);

	// Datapath: period, compare and mode registers, duty rescale, output register.
	// The duty percent is (compare+1)*100/(period+1) clamped to 100, from the iterative
	// divider; the new compare is new_period*duty/100 and the compare step is
	// period/100, both taken by multiplying with a reciprocal of 100.
	pwmkt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_byte      (key.key_byte),
		.ctl           (ctl),
		.stat          (stat),
		.res_valid     (res.valid),
		.res_ready     (res.ready),
		.compare_value (res.compare_value),
		.period_value  (res.period_value),
		.display_mode  (res.display_mode),
		.response      (res.response)
	);

endmodule

// File: hw/rtl/pwmkt_div.sv
module pwmkt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pwmkt_pkg::DIV_A_W-1:0]   dividend,
	input  logic [pwmkt_pkg::DIV_B_W-1:0]   divisor,
	output logic                            done,
	output logic [pwmkt_pkg::DIV_A_W-1:0]   quotient
);
	import pwmkt_pkg::*;

	logic [DIV_A_W-1:0]   quot_q;
	logic [DIV_B_W-1:0]   rem_q;
	logic [DIV_B_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_B_W:0]     shifted;
	logic [DIV_B_W:0]     diff;

	// One restoring step: bring down the next dividend bit, try the subtract
	assign shifted = {rem_q, quot_q[DIV_A_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_A_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			if (!diff[DIV_B_W]) begin
				rem_q  <= diff[DIV_B_W-1:0];
				quot_q <= {quot_q[DIV_A_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[DIV_B_W-1:0];
				quot_q <= {quot_q[DIV_A_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a run");
	a_quot_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !start) |=> $stable(quot_q))
		else $error("quotient changed while idle");

endmodule

// File: hw/rtl/pwmkt_ctrl.sv
module pwmkt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output pwmkt_pkg::dp_ctrl_t   ctl,
	input  pwmkt_pkg::dp_stat_t   stat
);
	import pwmkt_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		in_ready      = 1'b0;
		ctl.capture   = 1'b0;
		ctl.prep      = 1'b0;
		ctl.div_start = 1'b0;
		ctl.mul       = 1'b0;
		ctl.scale     = 1'b0;
		ctl.apply     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_nx    = ST_PREP;
				end
			end
			ST_PREP: begin
				// Only the period commands rescale the duty
				ctl.prep = 1'b1;
				case (stat.cmd) inside
					CMD_HALF, CMD_DOUBLE, CMD_PDEC, CMD_PINC:
						state_nx = ST_DIV_GO;
					default:
						state_nx = ST_APPLY;
				endcase
			end
			ST_DIV_GO: begin
				ctl.div_start = 1'b1;
				state_nx      = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				ctl.mul  = 1'b1;
				state_nx = ST_SCALE;
			end
			ST_SCALE: begin
				ctl.scale = 1'b1;
				state_nx  = ST_APPLY;
			end
			ST_APPLY: begin
				if (stat.out_free) begin
					ctl.apply = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	a_apply_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |-> stat.out_free)
		else $error("result written over a pending transaction");
	a_start_waits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |=> (state_q == ST_DIV_WAIT))
		else $error("divider started without a wait state");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> !in_ready)
		else $error("second key accepted while busy");

endmodule

// File: hw/rtl/pwmkt_dp.sv
module pwmkt_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            key_byte,
	input  pwmkt_pkg::dp_ctrl_t   ctl,
	output pwmkt_pkg::dp_stat_t   stat,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [15:0]           compare_value,
	output logic [15:0]           period_value,
	output logic                  display_mode,
	output logic [2:0]            response
);
	import pwmkt_pkg::*;

	logic [CNT_W-1:0]   compare_q;
	logic [CNT_W-1:0]   period_q;
	logic               mode_q;
	cmd_t               cmd_q;
	logic [DIV_A_W-1:0] prod_q;
	logic [CNT_W-1:0]   np_q;
	logic [CNT_W-1:0]   step_q;
	logic [CNT_W-1:0]   scl_q;

	logic               res_valid_q;
	logic [15:0]        out_cmp_q;
	logic [15:0]        out_per_q;
	logic               out_mode_q;
	resp_t              out_resp_q;

	logic [DIV_A_W-1:0] div_a;
	logic [DIV_B_W-1:0] div_b;
	logic               div_done;
	logic [DIV_A_W-1:0] div_quot;

	logic [CNT_W-1:0]   per_calc;
	logic [DUTY_W-1:0]  duty;
	logic [CNT_W-1:0]   step_raw;
	logic [CNT_W:0]     sum;
	logic [CNT_W-1:0]   cmp_nx;
	logic [CNT_W-1:0]   per_nx;
	logic               mode_nx;
	resp_t              resp_nx;

	// Floor of x/100 by multiplying with the rounded-up reciprocal
	function automatic logic [CNT_W-1:0] div_by_pct(input logic [DIV_A_W-1:0] x);
		logic [PRD_W-1:0] p;
		p = PRD_W'(x) * PRD_W'(RCP_100);
		return p[RCP_SHIFT +: CNT_W];
	endfunction

	// New period for the period commands
	always_comb begin
		case (cmd_q)
			CMD_HALF:
				per_calc = (period_q < CNT_W'(2)) ? CNT_W'(1) : (period_q >> 1);
			CMD_DOUBLE:
				per_calc = ((32'(period_q) > DOUBLE_LIMIT) || period_q[CNT_W-1]) ?
					CNT_MAX : (period_q << 1);
			CMD_PDEC:
				per_calc = (period_q < CNT_W'(2)) ? CNT_W'(1) : (period_q - 1'b1);
			CMD_PINC:
				per_calc = (period_q == CNT_MAX) ? CNT_MAX : (period_q + 1'b1);
			default:
				per_calc = period_q;
		endcase
	end

	// Clamp the duty percent
	assign duty = (div_quot > DIV_A_W'(PCT)) ? DUTY_W'(PCT) : div_quot[DUTY_W-1:0];

	// The divider only forms the duty percent: (compare+1)*100 / (period+1)
	assign div_a = prod_q;
	assign div_b = DIV_B_W'(period_q) + 1'b1;

	pwmkt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Compare step is period/100, at least one
	assign step_raw = div_by_pct(DIV_A_W'(period_q));

	// State after the command
	assign sum  = {1'b0, compare_q} + {1'b0, step_q};

	always_comb begin
		cmp_nx  = compare_q;
		per_nx  = period_q;
		mode_nx = mode_q;
		resp_nx = RESP_NONE;
		case (cmd_q)
			CMD_MODE: begin
				mode_nx = ~mode_q;
				resp_nx = mode_q ? RESP_GENERAL : RESP_VOLT;
			end
			CMD_INC: begin
				// compare at or above the period means full duty: hold compare at the period
				if (compare_q >= period_q) begin
					cmp_nx = period_q;
				end else if (sum[CNT_W]) begin
					cmp_nx = CNT_MAX;
				end else begin
					cmp_nx = sum[CNT_W-1:0];
				end
			end
			CMD_DEC: begin
				cmp_nx = (step_q > compare_q) ? '0 : (compare_q - step_q);
			end
			CMD_HALF, CMD_DOUBLE, CMD_PDEC, CMD_PINC: begin
				cmp_nx = scl_q;
				per_nx = np_q;
			end
			CMD_HELP: begin
				resp_nx = RESP_HELP;
			end
			CMD_NL: begin
				resp_nx = RESP_NEWLINE;
			end
			default: begin
				resp_nx = RESP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_q   <= CMP_RESET;
			period_q    <= PER_RESET;
			mode_q      <= 1'b0;
			cmd_q       <= CMD_NONE;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				cmd_q <= decode_key(key_byte);
			end
			if (ctl.apply) begin
				compare_q   <= cmp_nx;
				period_q    <= per_nx;
				mode_q      <= mode_nx;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.prep) begin
			prod_q <= (DIV_A_W'(compare_q) + 1'b1) * DIV_A_W'(PCT);
			np_q   <= per_calc;
			step_q <= (step_raw == '0) ? CNT_W'(1) : step_raw;
		end else if (ctl.mul) begin
			prod_q <= DIV_A_W'(np_q) * DIV_A_W'(duty);
		end
		if (ctl.scale) begin
			scl_q <= div_by_pct(prod_q);
		end
		if (ctl.apply) begin
			out_cmp_q  <= 16'(cmp_nx);
			out_per_q  <= 16'(per_nx);
			out_mode_q <= mode_nx;
			out_resp_q <= resp_nx;
		end
	end

	assign stat.cmd      = cmd_q;
	assign stat.div_done = div_done;
	assign stat.out_free = !res_valid_q || res_ready;

	assign res_valid     = res_valid_q;
	assign compare_value = out_cmp_q;
	assign period_value  = out_per_q;
	assign display_mode  = out_mode_q;
	assign response      = out_resp_q;

endmodule
